FILE: sv/three_level_priority_queue_top_macros.svh
// Assertion macros shared by the checkers of the three-level priority queue.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_TOP_MACROS_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: sv/tpq_pkg.sv
// Shared types and codes of the three-level priority queue.
`default_nettype none

package tpq_pkg;

   // Number of priority levels sharing the entry store.
   localparam int unsigned NUM_LEVELS = 3;

   // Field widths of the stream ports.
   localparam int unsigned DATA_IN_W   = 32;
   localparam int unsigned LEVEL_W     = 2;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned TOTAL_W     = 6;
   localparam int unsigned REQ_TDATA_W = 40;
   localparam int unsigned RSP_TDATA_W = 72;

   // Operation codes carried in the request tuser.
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Level codes.
   localparam logic [LEVEL_W-1:0] LVL_LOW     = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_NORMAL  = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_HIGH    = 2'd2;
   localparam logic [LEVEL_W-1:0] LVL_INVALID = 2'd3;

   // Status codes carried in the response tuser.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_LEVEL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_POP_RD,
      S_HEAD_RD,
      S_RESULT
   } state_type;

endpackage

`default_nettype wire

FILE: sv/three_level_priority_queue_top.sv
// Three-level strict priority queue: three FIFOs (low, normal, high) in one shared memory.
// Every request transaction (push or pop) produces exactly one response transaction that
// carries a status, the popped value, the front value with its valid flag and the total
// element count, all as they stand after the operation. The accepting edge commits the
// pointer and count update, together with the memory write of a push or the read of the
// popped entry. The following cycle reads the front entry of the highest non-empty level
// from the single-read-port entry memory. The result state then loads the response register
// once the previous response has been taken or is being taken. The next request is taken in
// the cycle after the response register has been loaded, so the block takes no new request
// until the last response is loaded. A response waiting to be taken stalls at most
// one transaction. The entry memory needs no clearing pass;
// entries are only read once written.
`default_nettype none

module three_level_priority_queue_top #(
   parameter int unsigned LEVEL_DEPTH = 16,
   parameter int unsigned DATA_WIDTH  = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request channel.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // tdata, from bit 0: data_value[31:0], priority_req[33:32], zero padding[39:34].
   input  wire logic [tpq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: cmd (0 push, 1 pop).
   input  wire logic                             req_tuser,
   // Response channel.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tdata, from bit 0: popped_value[31:0], head_value[63:32], head_valid[64],
   // total_count[70:65], zero padding[71].
   output logic      [tpq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // tuser: status[1:0].
   output logic      [tpq_pkg::STATUS_W-1:0]     rsp_tuser
);

   localparam int unsigned IDX_W  = $clog2(LEVEL_DEPTH);
   localparam int unsigned CNT_W  = $clog2(LEVEL_DEPTH + 1);
   localparam int unsigned MEM_DEPTH = tpq_pkg::NUM_LEVELS * LEVEL_DEPTH;
   localparam int unsigned ADDR_W = $clog2(MEM_DEPTH);
   localparam int unsigned SUM_W  = $clog2(MEM_DEPTH + 1);
   localparam logic [ADDR_W-1:0] BASE_NORMAL = ADDR_W'(LEVEL_DEPTH);
   localparam logic [ADDR_W-1:0] BASE_HIGH   = ADDR_W'(2 * LEVEL_DEPTH);

   // Control state.
   tpq_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff [tpq_pkg::NUM_LEVELS];
   logic [IDX_W-1:0] head_ff  [tpq_pkg::NUM_LEVELS];
   logic             rsp_valid_ff, rsp_valid_in;

   // Per-transaction payload registers.
   logic [tpq_pkg::STATUS_W-1:0]  status_ff;
   logic [tpq_pkg::DATA_IN_W-1:0] popped_ff;
   logic [tpq_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [tpq_pkg::DATA_IN_W-1:0] rsp_popped_ff;
   logic [tpq_pkg::DATA_IN_W-1:0] rsp_head_ff;
   logic                          rsp_head_valid_ff;
   logic [tpq_pkg::TOTAL_W-1:0]   rsp_total_ff;

   // Request fields.
   logic [tpq_pkg::DATA_IN_W-1:0] req_data_value;
   logic [tpq_pkg::LEVEL_W-1:0]   req_priority;
   logic                          req_cmd;

   // Datapath and handshake signals.
   logic                          accept;
   logic                          any_nonempty;
   logic [tpq_pkg::LEVEL_W-1:0]   top_lvl;
   logic [tpq_pkg::LEVEL_W-1:0]   sel_lvl;
   logic [CNT_W-1:0]              sel_cnt;
   logic [IDX_W-1:0]              sel_head;
   logic [ADDR_W-1:0]             sel_base;
   logic                          push_bad;
   logic                          push_full;
   logic                          push_ok;
   logic                          pop_ok;
   logic [tpq_pkg::STATUS_W-1:0]  item_status;
   logic [CNT_W:0]                tail_sum;
   logic [CNT_W:0]                tail_wrap;
   logic [IDX_W-1:0]              tail_idx;
   logic [IDX_W:0]                head_sum;
   logic [IDX_W-1:0]              head_next;
   logic [SUM_W-1:0]              total_sum;
   logic [63:0]                   wr_wide;
   logic [63:0]                   rd_wide;
   logic [tpq_pkg::DATA_IN_W-1:0] rd_low;
   logic                          head_rd_state;
   logic                          capture_pop;
   logic                          load_rsp;
   logic                          ram_wr_en;
   logic                          ram_rd_en;
   logic [ADDR_W-1:0]             ram_wr_addr;
   logic [ADDR_W-1:0]             ram_rd_addr;
   logic [DATA_WIDTH-1:0]         ram_wr_data;
   logic [DATA_WIDTH-1:0]         ram_rd_data;

   // Unpack the request transaction.
   assign req_data_value = req_tdata[tpq_pkg::DATA_IN_W-1:0];
   assign req_priority   = req_tdata[tpq_pkg::DATA_IN_W +: tpq_pkg::LEVEL_W];
   assign req_cmd        = req_tuser;
   assign accept         = req_tvalid & req_tready;

   // Highest non-empty level, from the counts held in flip-flops.
   always_comb begin
      any_nonempty = 1'b1;
      if (count_ff[2] != '0) begin
         top_lvl = tpq_pkg::LVL_HIGH;
      end else if (count_ff[1] != '0) begin
         top_lvl = tpq_pkg::LVL_NORMAL;
      end else begin
         top_lvl      = tpq_pkg::LVL_LOW;
         any_nonempty = (count_ff[0] != '0);
      end
   end

   // One level is looked at per cycle: the named level of a push, otherwise the top level.
   always_comb begin
      if (state_ff == tpq_pkg::S_IDLE && req_cmd == tpq_pkg::CMD_PUSH) begin
         sel_lvl = req_priority;
      end else begin
         sel_lvl = top_lvl;
      end
   end

   always_comb begin
      case (sel_lvl)
         tpq_pkg::LVL_LOW: begin
            sel_cnt  = count_ff[0];
            sel_head = head_ff[0];
            sel_base = '0;
         end
         tpq_pkg::LVL_NORMAL: begin
            sel_cnt  = count_ff[1];
            sel_head = head_ff[1];
            sel_base = BASE_NORMAL;
         end
         tpq_pkg::LVL_HIGH: begin
            sel_cnt  = count_ff[2];
            sel_head = head_ff[2];
            sel_base = BASE_HIGH;
         end
         default: begin
            sel_cnt  = '0;
            sel_head = '0;
            sel_base = '0;
         end
      endcase
   end

   // Tail slot of a push and the advanced head of a pop, both wrapped at the level depth.
   always_comb begin
      tail_sum = (CNT_W + 1)'(sel_head) + (CNT_W + 1)'(sel_cnt);
      if (tail_sum >= (CNT_W + 1)'(LEVEL_DEPTH)) begin
         tail_wrap = tail_sum - (CNT_W + 1)'(LEVEL_DEPTH);
      end else begin
         tail_wrap = tail_sum;
      end
      tail_idx = tail_wrap[IDX_W-1:0];
      head_sum = (IDX_W + 1)'(sel_head) + (IDX_W + 1)'(1);
      if (head_sum == (IDX_W + 1)'(LEVEL_DEPTH)) begin
         head_next = '0;
      end else begin
         head_next = head_sum[IDX_W-1:0];
      end
   end

   // Decide the outcome of an accepted transaction.
   always_comb begin
      push_bad  = (req_priority == tpq_pkg::LVL_INVALID);
      push_full = (sel_cnt == CNT_W'(LEVEL_DEPTH));
      push_ok   = accept & (req_cmd == tpq_pkg::CMD_PUSH) & ~push_bad & ~push_full;
      pop_ok    = accept & (req_cmd == tpq_pkg::CMD_POP) & any_nonempty;
      if (req_cmd == tpq_pkg::CMD_POP) begin
         item_status = any_nonempty ? tpq_pkg::STATUS_OK : tpq_pkg::STATUS_EMPTY;
      end else if (push_bad) begin
         item_status = tpq_pkg::STATUS_BAD_LEVEL;
      end else if (push_full) begin
         item_status = tpq_pkg::STATUS_FULL;
      end else begin
         item_status = tpq_pkg::STATUS_OK;
      end
   end

   // Width conversion between the 32-bit fields and the stored width.
   assign wr_wide     = 64'(req_data_value);
   assign ram_wr_data = wr_wide[DATA_WIDTH-1:0];
   assign rd_wide     = 64'(ram_rd_data);
   assign rd_low      = rd_wide[tpq_pkg::DATA_IN_W-1:0];

   // Total element count after the operation.
   assign total_sum = SUM_W'(count_ff[0]) + SUM_W'(count_ff[1]) + SUM_W'(count_ff[2]);

   // Next state.
   always_comb begin
      case (state_ff)
         tpq_pkg::S_IDLE: begin
            if (pop_ok) begin
               state_in = tpq_pkg::S_POP_RD;
            end else if (accept) begin
               state_in = tpq_pkg::S_HEAD_RD;
            end else begin
               state_in = tpq_pkg::S_IDLE;
            end
         end
         tpq_pkg::S_POP_RD:  state_in = tpq_pkg::S_RESULT;
         tpq_pkg::S_HEAD_RD: state_in = tpq_pkg::S_RESULT;
         tpq_pkg::S_RESULT: begin
            state_in = load_rsp ? tpq_pkg::S_IDLE : tpq_pkg::S_RESULT;
         end
         default: state_in = tpq_pkg::S_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready    = 1'b0;
      head_rd_state = 1'b0;
      capture_pop   = 1'b0;
      load_rsp      = 1'b0;
      case (state_ff)
         tpq_pkg::S_IDLE: begin
            req_tready = 1'b1;
         end
         tpq_pkg::S_POP_RD: begin
            head_rd_state = 1'b1;
            capture_pop   = 1'b1;
         end
         tpq_pkg::S_HEAD_RD: begin
            head_rd_state = 1'b1;
         end
         tpq_pkg::S_RESULT: begin
            load_rsp = ~rsp_valid_ff | rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Memory access: push writes its tail slot; a pop and each front lookup read a head slot.
   assign ram_wr_en   = push_ok;
   assign ram_wr_addr = sel_base + ADDR_W'(tail_idx);
   assign ram_rd_en   = pop_ok | (head_rd_state & any_nonempty);
   assign ram_rd_addr = sel_base + ADDR_W'(sel_head);

   tpq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MEM_DEPTH)
   ) u_tpq_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The response register stays full until the consumer takes it.
   assign rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp_tready);

   // Control state: sequencer, level counts, head pointers and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < tpq_pkg::NUM_LEVELS; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < tpq_pkg::NUM_LEVELS; i++) begin
            if (sel_lvl == tpq_pkg::LEVEL_W'(i)) begin
               if (push_ok) begin
                  count_ff[i] <= count_ff[i] + CNT_W'(1);
               end else if (pop_ok) begin
                  count_ff[i] <= count_ff[i] - CNT_W'(1);
                  head_ff[i]  <= head_next;
               end
            end
         end
      end
   end

   // Per-transaction payload: status at acceptance, popped value at the end of the pop-read state.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= item_status;
         popped_ff <= '0;
      end else if (capture_pop) begin
         popped_ff <= rd_low;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff     <= status_ff;
         rsp_popped_ff     <= popped_ff;
         rsp_head_ff       <= any_nonempty ? rd_low : '0;
         rsp_head_valid_ff <= any_nonempty;
         rsp_total_ff      <= tpq_pkg::TOTAL_W'(total_sum);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_total_ff, rsp_head_valid_ff, rsp_head_ff, rsp_popped_ff};

endmodule

`default_nettype wire

FILE: sv/tpq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tpq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 48
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/tpq_checker.sv
// Port-level checker of the three-level priority queue, bound to its top level.
`default_nettype none

`include "three_level_priority_queue_top_macros.svh"

module tpq_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [tpq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic [tpq_pkg::STATUS_W-1:0]     rsp_tuser
);

   // A stalled response transaction keeps its contents.
   `TPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // With every level empty, the front value and the total are zero.
   `TPQ_ASSERT_SAME(a_empty_front, clock, reset, rsp_tvalid && !rsp_tdata[64], rsp_tdata[63:32] == 32'd0 && rsp_tdata[70:65] == 6'd0)

   // A pop on empty leaves every level empty.
   `TPQ_ASSERT_SAME(a_pop_empty, clock, reset, rsp_tvalid && rsp_tuser == tpq_pkg::STATUS_EMPTY, !rsp_tdata[64])

   // A rejected transaction never returns a popped value.
   `TPQ_ASSERT_SAME(a_reject_no_pop, clock, reset, rsp_tvalid && rsp_tuser != tpq_pkg::STATUS_OK, rsp_tdata[31:0] == 32'd0)

endmodule

bind three_level_priority_queue_top tpq_checker u_tpq_checker (.*);

`default_nettype wire
